### rtl/keyed_value_table_core_macros.svh
// ---------------------------------------------------------------------------
// keyed value table assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef KEYED_VALUE_TABLE_CORE_MACROS_SVH
`define KEYED_VALUE_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// check on an explicit clock and active-low reset
`define KVT_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check on the block clock and reset
`define KVT_ASSERT(lbl, prop, msg) `KVT_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)
`else
`define KVT_ASSERT_AT(lbl, clk, rstn, prop, msg)
`define KVT_ASSERT(lbl, prop, msg)
`endif

`endif

### rtl/kvt_pkg.sv
// ---------------------------------------------------------------------------
// kvt_pkg
// shared constants, request modes, status codes and sequencer states
// ---------------------------------------------------------------------------
package kvt_pkg;

  // default geometry
  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned KEY_BITS_DEF    = 8;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  // fixed field widths
  localparam int unsigned MODE_BITS   = 3;
  localparam int unsigned STATUS_BITS = 2;

  // request modes
  typedef enum logic [MODE_BITS-1:0] {
    MODE_CLEAR  = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_ERASE  = 3'd2,
    MODE_GET    = 3'd3,
    MODE_COUNT  = 3'd4
  } mode_e;

  // result status codes
  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_PRESENT   = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_e;

endpackage

### rtl/kvt_mem.sv
// ---------------------------------------------------------------------------
// kvt_mem
// entry memory: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module kvt_mem #(
  parameter int unsigned DEPTH = kvt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned WIDTH = kvt_pkg::KEY_BITS_DEF + kvt_pkg::VALUE_BITS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/keyed_value_table_core.sv
// ---------------------------------------------------------------------------
// keyed_value_table_core: bounded key/value table in insertion order
// clear, a full insert or any request on an empty table goes from idle straight
// to the done state and then into the output register; a new request is taken only in idle
// scans read one entry a cycle and end at a key hit or at the last entry in use;
// a count scan always reads every entry in use
// erase then moves the later entries down, one per cycle; output is registered
// reset: sequencer idle, table empty, memory contents left as they are
// ---------------------------------------------------------------------------
`include "keyed_value_table_core_macros.svh"

module keyed_value_table_core #(
  parameter int unsigned TABLE_DEPTH = kvt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = kvt_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS  = kvt_pkg::VALUE_BITS_DEF,
  localparam int unsigned CW         = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [kvt_pkg::MODE_BITS-1:0]    mode_i,
  input  logic [KEY_BITS-1:0]              key_i,
  input  logic signed [VALUE_BITS-1:0]     value_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [kvt_pkg::STATUS_BITS-1:0]  status_o,
  output logic signed [VALUE_BITS-1:0]     found_value_o,
  output logic [CW-1:0]                    match_count_o,
  output logic [CW-1:0]                    entries_used_o
);

  import kvt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned EW = KEY_BITS + VALUE_BITS;

  // sequencer and request registers
  state_e                  state_q, state_d;
  logic [MODE_BITS-1:0]    mode_q, mode_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [VALUE_BITS-1:0]   value_q, value_d;
  logic [CW-1:0]           fill_q, fill_d;

  // scan and shift pointers
  logic [CW-1:0]           issue_q, issue_d;
  logic                    chk_vld_q, chk_vld_d;
  logic [CW-1:0]           chk_idx_q, chk_idx_d;
  logic [CW-1:0]           shift_rd_q, shift_rd_d;
  logic                    wb_vld_q, wb_vld_d;
  logic [AW-1:0]           wb_addr_q, wb_addr_d;

  // result being built
  status_e                 res_status_q, res_status_d;
  logic [VALUE_BITS-1:0]   res_found_q, res_found_d;
  logic [CW-1:0]           res_match_q, res_match_d;

  // output register
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [VALUE_BITS-1:0]   out_found_q;
  logic [CW-1:0]           out_match_q;
  logic [CW-1:0]           out_used_q;

  // memory port
  logic                    mem_rd_en;
  logic [AW-1:0]           mem_rd_addr;
  logic [EW-1:0]           mem_rd_data;
  logic                    mem_wr_en;
  logic [AW-1:0]           mem_wr_addr;
  logic [EW-1:0]           mem_wr_data;

  // decode
  logic                    fill_zero, fill_full;
  logic [KEY_BITS-1:0]     rd_key;
  logic [VALUE_BITS-1:0]   rd_val;
  logic                    key_hit, val_hit, chk_last;
  logic                    scan_rd, shift_rd;
  logic [CW-1:0]           shift_prev;
  logic                    out_free, out_load;

  kvt_mem #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (EW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  // request handshake and shared decode
  assign in_stall_o = (state_q != S_IDLE);
  assign fill_zero  = (fill_q == '0);
  assign fill_full  = (fill_q == CW'(TABLE_DEPTH));
  assign rd_key     = mem_rd_data[EW-1:VALUE_BITS];
  assign rd_val     = mem_rd_data[VALUE_BITS-1:0];
  assign key_hit    = chk_vld_q && (rd_key == key_q);
  assign val_hit    = chk_vld_q && (rd_val == value_q);
  assign chk_last   = chk_vld_q && (chk_idx_q == fill_q - CW'(1));
  assign scan_rd    = (issue_q < fill_q);
  assign shift_rd   = (shift_rd_q < fill_q);
  assign shift_prev = shift_rd_q - CW'(1);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DONE) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            MODE_INSERT: state_d = (fill_full || fill_zero) ? S_DONE : S_SCAN;
            MODE_ERASE, MODE_GET, MODE_COUNT: state_d = fill_zero ? S_DONE : S_SCAN;
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (mode_q == MODE_COUNT) begin
          if (chk_last) state_d = S_DONE;
        end else if (key_hit) begin
          state_d = (mode_q == MODE_ERASE) ? S_SHIFT : S_DONE;
        end else if (chk_last) begin
          state_d = S_DONE;
        end
      end
      S_SHIFT: begin
        if (!shift_rd && !wb_vld_q) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_d       = mode_q;
    key_d        = key_q;
    value_d      = value_q;
    fill_d       = fill_q;
    issue_d      = issue_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    shift_rd_d   = shift_rd_q;
    wb_vld_d     = 1'b0;
    wb_addr_d    = wb_addr_q;
    res_status_d = res_status_q;
    res_found_d  = res_found_q;
    res_match_d  = res_match_q;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = issue_q[AW-1:0];
    mem_wr_en    = 1'b0;
    mem_wr_addr  = fill_q[AW-1:0];
    mem_wr_data  = {key_q, value_q};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d       = mode_i;
          key_d        = key_i;
          value_d      = value_i;
          issue_d      = '0;
          res_status_d = STAT_OK;
          res_found_d  = '0;
          res_match_d  = '0;
          case (mode_i)
            MODE_CLEAR: fill_d = '0;
            MODE_INSERT: begin
              if (fill_full) begin
                res_status_d = STAT_FULL;
              end else if (fill_zero) begin
                // empty table: append without a scan
                mem_wr_en   = 1'b1;
                mem_wr_data = {key_i, value_i};
                fill_d      = CW'(1);
              end
            end
            MODE_ERASE, MODE_GET: begin
              if (fill_zero) res_status_d = STAT_NOT_FOUND;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        // read one entry a cycle, compare it the cycle after
        mem_rd_en   = scan_rd;
        mem_rd_addr = issue_q[AW-1:0];
        chk_vld_d   = scan_rd;
        chk_idx_d   = issue_q;
        if (scan_rd) issue_d = issue_q + CW'(1);
        if (chk_vld_q) begin
          case (mode_q)
            MODE_INSERT: begin
              if (key_hit) begin
                res_status_d = STAT_PRESENT;
              end else if (chk_last) begin
                mem_wr_en = 1'b1;
                fill_d    = fill_q + CW'(1);
              end
            end
            MODE_ERASE: begin
              if (key_hit) begin
                shift_rd_d = chk_idx_q + CW'(1);
              end else if (chk_last) begin
                res_status_d = STAT_NOT_FOUND;
              end
            end
            MODE_GET: begin
              if (key_hit) begin
                res_found_d = rd_val;
              end else if (chk_last) begin
                res_status_d = STAT_NOT_FOUND;
              end
            end
            MODE_COUNT: begin
              if (val_hit) res_match_d = res_match_q + CW'(1);
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        // read entry i+1, write it back to entry i the next cycle
        mem_rd_en   = shift_rd;
        mem_rd_addr = shift_rd_q[AW-1:0];
        wb_vld_d    = shift_rd;
        wb_addr_d   = shift_prev[AW-1:0];
        mem_wr_en   = wb_vld_q;
        mem_wr_addr = wb_addr_q;
        mem_wr_data = mem_rd_data;
        if (shift_rd) shift_rd_d = shift_rd_q + CW'(1);
        if (!shift_rd && !wb_vld_q) fill_d = fill_q - CW'(1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      chk_vld_q   <= 1'b0;
      wb_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      chk_vld_q <= chk_vld_d;
      wb_vld_q  <= wb_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    value_q      <= value_d;
    issue_q      <= issue_d;
    chk_idx_q    <= chk_idx_d;
    shift_rd_q   <= shift_rd_d;
    wb_addr_q    <= wb_addr_d;
    res_status_q <= res_status_d;
    res_found_q  <= res_found_d;
    res_match_q  <= res_match_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_match_q  <= res_match_q;
      out_used_q   <= fill_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_value_o  = out_found_q;
  assign match_count_o  = out_match_q;
  assign entries_used_o = out_used_q;

  // checks
  `KVT_ASSERT(a_fill_bound, fill_q <= CW'(TABLE_DEPTH), "fill count beyond table depth")
  `KVT_ASSERT(a_wr_in_range, mem_wr_en |-> (CW'(mem_wr_addr) <= fill_q), "write past fill")
  `KVT_ASSERT(a_shift_nonempty, (state_q == S_SHIFT) |-> !fill_zero, "shift on empty table")
  `KVT_ASSERT(a_match_bound, res_match_q <= fill_q || state_q == S_IDLE, "match beyond fill")
  `KVT_ASSERT(a_clear_empty, (out_load && mode_q == MODE_CLEAR) |=> (entries_used_o == '0), "clear")

endmodule
